>>> design/ccr_pkg.sv
// ----------------------------------------------------------------------------
// ccr_pkg
// Shared constants, types and helpers for the color class rebalancer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ccr_pkg;

    localparam int NUM_COLORS = 64;
    localparam int COUNT_BITS = 32;

    localparam int CLR_W    = (NUM_COLORS > 1) ? $clog2(NUM_COLORS) : 1;
    localparam int LIMIT_W  = 32;
    localparam int CMP_W    = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;
    localparam int NCOL_W   = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AVG_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLORS    = 2'd2;

    // operation codes
    localparam logic OP_TALLY     = 1'b0;
    localparam logic OP_REBALANCE = 1'b1;

    // target choice policy
    localparam logic POL_FIRST_FIT  = 1'b0;
    localparam logic POL_LEAST_USED = 1'b1;

    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [CLR_W-1:0]      t_color_idx;

    typedef struct packed {
        logic       rd_en;
        t_color_idx rd_addr;
        logic       wr_en;
        t_color_idx wr_addr;
        t_count     wr_data;
    } t_mem_req;

    function automatic t_count sat_inc(input t_count v);
        t_count r;
        r = (v == '1) ? v : v + t_count'(1);
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/ccr_pop_mem.sv
// ----------------------------------------------------------------------------
// ccr_pop_mem
// Population counter memory: one write and one registered read per cycle.
// Per-entry valid bits make every counter read as zero after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ccr_pop_mem
    import ccr_pkg::*;
(
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire t_mem_req i_req,
    output t_count        o_rd_data
);

    t_count                r_mem [NUM_COLORS];
    logic [NUM_COLORS-1:0] r_vld;
    t_count                r_rd_data;
    logic                  r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_vld[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_vld[i_req.rd_addr];
            end
        end
    end

    // entries never written since reset read as zero
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

`default_nettype wire

>>> design/color_class_rebalancer.sv
// ----------------------------------------------------------------------------
// color_class_rebalancer
// Per-color population counters with tally and rebalance operations.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) carries op, vertex_color and
// neighbor_mask; the output channel (o_out_valid / i_out_stall) returns one
// result per item: new_color and moved. A transfer happens when valid is high
// and stall is low.
// Counters live in a 64-entry memory with a registered read.
// An item whose color is not in use goes from accept straight to its final
// step; a tally or a rebalance of a class not over the limit first reads
// its own counter. A rebalance of an oversized class reads its own counter,
// then scans every class in use through the memory read port, one per cycle,
// then, if an eligible target was found, writes the target and the old
// class back. Classes in use are those below colors_in_use capped at 64.
// One item is worked at a time; the next item is accepted in the cycle after
// the result is loaded, even if the receiver still stalls it. A stalled
// result holds until taken; the next result waits in its final step.
// Reset clears all counters at once (valid bits), sets policy to first fit,
// avg_limit to 0 and colors_in_use to 64. Configure only while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module color_class_rebalancer
    import ccr_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [CFG_DATA_W-1:0] i_cfg_data,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  wire                  i_op,
    input  wire [5:0]            i_vertex_color,
    input  wire [63:0]           i_neighbor_mask,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output logic [5:0]           o_new_color,
    output logic                 o_moved
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_RD_OWN = 6'b000010,
        S_SCAN   = 6'b000100,
        S_WR_TGT = 6'b001000,
        S_WR_OWN = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state                r_state, n_state;
    logic                  r_policy;
    logic [LIMIT_W-1:0]    r_avg_limit;
    logic [NCOL_W-1:0]     r_colors;

    logic                  r_op;
    logic [5:0]            r_color;
    t_color_idx            r_own;
    logic [NUM_COLORS-1:0] r_mask;
    t_count                r_own_pop;
    t_color_idx            r_idx;
    logic                  r_found;
    t_color_idx            r_best_idx;
    t_count                r_best_pop;
    logic [5:0]            r_res_color;
    logic                  r_res_moved;

    logic                  r_out_valid;
    logic [5:0]            r_out_color;
    logic                  r_out_moved;

    logic [NCOL_W-1:0]     n_eff;
    logic                  in_use;
    logic                  accept;
    logic                  out_free;
    t_mem_req              mem_req;
    t_count                rd_data;
    logic [CMP_W-1:0]      rd_cmp;
    logic [CMP_W-1:0]      lim_cmp;
    logic                  eligible;
    logic                  take;
    logic                  last_idx;

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy    <= POL_FIRST_FIT;
            r_avg_limit <= '0;
            r_colors    <= NCOL_W'(64);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_POLICY:    r_policy    <= i_cfg_data[0];
                CFG_AVG_LIMIT: r_avg_limit <= i_cfg_data[LIMIT_W-1:0];
                CFG_COLORS:    r_colors    <= i_cfg_data[NCOL_W-1:0];
                default: ;
            endcase
        end
    end

    assign n_eff  = (r_colors > NCOL_W'(NUM_COLORS)) ? NCOL_W'(NUM_COLORS) : r_colors;
    assign in_use = {1'b0, i_vertex_color} < n_eff;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    // ---------------------------------------------------------------- memory
    ccr_pop_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    assign rd_cmp  = CMP_W'(rd_data);
    assign lim_cmp = CMP_W'(r_avg_limit);

    assign eligible = (r_idx != r_own) && !r_mask[r_idx] && (rd_cmp < lim_cmp);
    assign take     = eligible &&
                      (!r_found || ((r_policy == POL_LEAST_USED) && (rd_data < r_best_pop)));
    assign last_idx = (NCOL_W'(r_idx) == (n_eff - NCOL_W'(1)));

    always_comb begin
        mem_req = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                mem_req.rd_en   = accept;
                mem_req.rd_addr = i_vertex_color[CLR_W-1:0];
                if (accept) begin
                    n_state = in_use ? S_RD_OWN : S_DONE;
                end
            end
            S_RD_OWN: begin
                if (r_op == OP_TALLY) begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = r_own;
                    mem_req.wr_data = sat_inc(rd_data);
                    n_state         = S_DONE;
                end else if (rd_cmp > lim_cmp) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = '0;
                    n_state         = S_SCAN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                if (last_idx) begin
                    n_state = (r_found || take) ? S_WR_TGT : S_DONE;
                end else begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = r_idx + t_color_idx'(1);
                end
            end
            S_WR_TGT: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = r_best_idx;
                mem_req.wr_data = sat_inc(r_best_pop);
                n_state         = S_WR_OWN;
            end
            S_WR_OWN: begin
                // own class is above the limit, so this cannot underflow
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = r_own;
                mem_req.wr_data = r_own_pop - t_count'(1);
                n_state         = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_RD_OWN) begin
                r_found <= 1'b0;
            end else if (r_state == S_SCAN && take) begin
                r_found <= 1'b1;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item payload and scan datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op        <= i_op;
            r_color     <= i_vertex_color;
            r_own       <= i_vertex_color[CLR_W-1:0];
            r_mask      <= i_neighbor_mask[NUM_COLORS-1:0];
            r_res_color <= i_vertex_color;
            r_res_moved <= 1'b0;
        end
        if (r_state == S_RD_OWN) begin
            r_own_pop <= rd_data;
            r_idx     <= '0;
        end
        if (r_state == S_SCAN) begin
            r_idx <= r_idx + t_color_idx'(1);
            if (take) begin
                r_best_idx <= r_idx;
                r_best_pop <= rd_data;
            end
        end
        if (r_state == S_WR_TGT) begin
            r_res_color <= 6'(r_best_idx);
            r_res_moved <= 1'b1;
        end
        if (r_state == S_DONE && out_free) begin
            r_out_color <= r_res_color;
            r_out_moved <= r_res_moved;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_new_color = r_out_color;
    assign o_moved     = r_out_moved;

    // ------------------------------------------------------------ assertions
    a_tgt_then_own: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WR_TGT |=> r_state == S_WR_OWN)
        else $error("target write not followed by old class write");

    a_tgt_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WR_TGT |-> r_found && (r_best_idx != r_own))
        else $error("target write without a valid target");

    a_done_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && out_free |=> (r_state == S_IDLE) && r_out_valid)
        else $error("finished result not loaded");

    a_tally_no_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && (r_op == OP_TALLY) |-> !r_res_moved
                                && (r_res_color == r_color))
        else $error("tally reported a move");

endmodule

`default_nettype wire
